### hdl/assert_macros.svh
// Assertion helpers shared by the RTL. Every check is sampled on the rising
// clock and is switched off while the reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

### hdl/fqs_pkg.sv
package fqs_pkg;

  localparam int QueueDepth = 16;
  localparam int PtrW       = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW       = $clog2(QueueDepth + 1);
  localparam int DataW      = 32;
  localparam int PosW       = 5;

  localparam logic [1:0] FUNC_ENQ  = 2'd0;
  localparam logic [1:0] FUNC_DEQ  = 2'd1;
  localparam logic [1:0] FUNC_SRCH = 2'd2;
  localparam logic [1:0] FUNC_PEEK = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [DataW-1:0] data_out;
    logic                    is_match;
    logic [PosW-1:0]         match_position;
    logic [PosW-1:0]         match_total;
    logic                    last;
  } result_t;

  // Circular pointer increment that wraps after the last entry.
  function automatic logic [PtrW-1:0] next_index(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] n;
    if (p == PtrW'(QueueDepth - 1)) begin
      n = '0;
    end else begin
      n = p + PtrW'(1);
    end
    return n;
  endfunction

endpackage

### hdl/fifo_queue_with_search.sv
// Bounded first-in first-out queue of QueueDepth signed 32-bit words with a
// linear search. Each request carries an operation: enqueue, dequeue, peek
// at the head, or search for a key. Enqueue, dequeue and peek each give one
// result; a search gives one result for every entry equal to the key, in
// order from head to tail and tagged with its 1-based position, followed by
// a final result with the match count and last set. Enqueue on a full queue
// is dropped with a full status, and any other operation on an empty queue
// gives a single underflow result. The entries live in one single-port-read
// memory with a registered read. An enqueue finishes in the idle state; a
// dequeue or peek passes through a read state for the memory read; a search
// scans one entry per cycle through the single read port, holding while a
// matching entry waits for space in the output queue, and then issues the
// count. Results pass through a two-entry output queue; a back-pressured
// output stalls both the results and the taking of new requests.
module fifo_queue_with_search import fqs_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              func_i,
  input  logic signed [DataW-1:0] push_value_i,
  input  logic signed [DataW-1:0] search_key_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [1:0]              status_o,
  output logic signed [DataW-1:0] data_out_o,
  output logic                    is_match_o,
  output logic [PosW-1:0]         match_position_o,
  output logic [PosW-1:0]         match_total_o,
  output logic                    last_o
);

`include "assert_macros.svh"

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_FINAL
  } state_e;

  state_e                  state_q, state_d;
  logic [PtrW-1:0]         head_q, head_d;
  logic [PtrW-1:0]         tail_q, tail_d;
  logic [CntW-1:0]         occ_q, occ_d;
  logic [PtrW-1:0]         scan_ptr_q, scan_ptr_d;
  logic [CntW-1:0]         idx_q, idx_d;
  logic [CntW-1:0]         hits_q, hits_d;
  logic [DataW-1:0]        key_q, key_d;

  logic                    mem_we;
  logic                    mem_re;
  logic [PtrW-1:0]         mem_raddr;
  logic [DataW-1:0]        mem_rdata;

  logic                    space;
  logic                    accept;
  logic                    empty;
  logic                    full;
  logic                    hit;
  logic                    res_push;
  result_t                 res;
  result_t                 res_out;

  fqs_ram #(
    .Width(DataW),
    .Depth(QueueDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (tail_q),
    .wdata_i (push_value_i),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  fqs_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_push),
    .res_i       (res),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_out)
  );

  // A request is taken only from the idle state and only when the output
  // queue can hold its first result. Multi-result work then paces itself on
  // the free space of that queue.
  assign in_ready_o = (state_q == S_IDLE) && space;
  assign accept     = in_valid_i && in_ready_o;
  assign empty      = (occ_q == '0);
  assign full       = (occ_q == CntW'(QueueDepth));
  assign hit        = (mem_rdata == key_q);

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    tail_d     = tail_q;
    occ_d      = occ_q;
    scan_ptr_d = scan_ptr_q;
    idx_d      = idx_q;
    hits_d     = hits_q;
    key_d      = key_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = head_q;
    res_push   = 1'b0;
    res        = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (func_i)
            FUNC_ENQ: begin
              res_push = 1'b1;
              res.last = 1'b1;
              if (full) begin
                res.status = ST_FULL;
              end else begin
                res.status = ST_OK;
                mem_we     = 1'b1;
                tail_d     = next_index(tail_q);
                occ_d      = occ_q + CntW'(1);
              end
            end
            FUNC_DEQ, FUNC_PEEK: begin
              if (empty) begin
                res_push   = 1'b1;
                res.status = ST_EMPTY;
                res.last   = 1'b1;
              end else begin
                // For a dequeue the head pointer moves now; the read already holds its address.
                mem_re  = 1'b1;
                state_d = S_READ;
                if (func_i == FUNC_DEQ) begin
                  head_d = next_index(head_q);
                  occ_d  = occ_q - CntW'(1);
                end
              end
            end
            FUNC_SRCH: begin
              if (empty) begin
                res_push   = 1'b1;
                res.status = ST_EMPTY;
                res.last   = 1'b1;
              end else begin
                mem_re     = 1'b1;
                key_d      = search_key_i;
                scan_ptr_d = next_index(head_q);
                idx_d      = '0;
                hits_d     = '0;
                state_d    = S_SCAN;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_READ: begin
        res_push     = 1'b1;
        res.status   = ST_OK;
        res.data_out = mem_rdata;
        res.last     = 1'b1;
        state_d      = S_IDLE;
      end
      S_SCAN: begin
        // A matching entry waits with its read data held until it has a slot.
        if (!hit || space) begin
          if (hit) begin
            res_push           = 1'b1;
            res.status         = ST_OK;
            res.is_match       = 1'b1;
            res.match_position = PosW'(idx_q + CntW'(1));
          end
          hits_d = hits_q + CntW'(hit);
          if ((idx_q + CntW'(1)) == occ_q) begin
            state_d = S_FINAL;
          end else begin
            mem_re     = 1'b1;
            mem_raddr  = scan_ptr_q;
            scan_ptr_d = next_index(scan_ptr_q);
            idx_d      = idx_q + CntW'(1);
          end
        end
      end
      S_FINAL: begin
        if (space) begin
          res_push        = 1'b1;
          res.status      = ST_OK;
          res.match_total = PosW'(hits_q);
          res.last        = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      head_q     <= '0;
      tail_q     <= '0;
      occ_q      <= '0;
      scan_ptr_q <= '0;
      idx_q      <= '0;
      hits_q     <= '0;
      key_q      <= '0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      occ_q      <= occ_d;
      scan_ptr_q <= scan_ptr_d;
      idx_q      <= idx_d;
      hits_q     <= hits_d;
      key_q      <= key_d;
    end
  end

  assign status_o         = res_out.status;
  assign data_out_o       = res_out.data_out;
  assign is_match_o       = res_out.is_match;
  assign match_position_o = res_out.match_position;
  assign match_total_o    = res_out.match_total;
  assign last_o           = res_out.last;

  `ASSERT_CLK(a_occ_bound, occ_q <= CntW'(QueueDepth), "occupancy above queue depth")
  `ASSERT_NEVER(a_push_no_space, res_push && !space, "result pushed into full output queue")
  `ASSERT_CLK(a_scan_idx, (state_q == S_SCAN) |-> (idx_q < occ_q), "scan index past occupancy")
  `ASSERT_CLK(a_scan_occ, (state_q == S_SCAN) |=> $stable(occ_q), "occupancy changed during a search")

endmodule

### hdl/fqs_ram.sv
module fqs_ram #(
  parameter int Width = 32,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/fqs_out_buf.sv
module fqs_out_buf import fqs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t res_i,
  output logic    space_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t res_o
);

  // Two result slots, so a new request can be taken while one result waits.
  result_t    slot_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign pop         = (cnt_q != 2'd0) && out_ready_i;
  assign out_valid_o = (cnt_q != 2'd0);
  assign space_o     = (cnt_q != 2'd2);
  assign res_o       = slot_q[rd_q];

  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= res_i;
    end
  end

endmodule

### tb/tb_fifo_queue_with_search.sv
`timescale 1ns / 100ps

module tb_fifo_queue_with_search import fqs_pkg::*; ();

  // Run length and pressure knobs.
  localparam int unsigned ItemsTarget = 220;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned HoldAfter   = 40;   // results seen before the long stall
  localparam int unsigned HoldCycles  = 120;  // length of the long output stall
  localparam int unsigned DrainCycles = 20;   // settling time once nothing is pending

  // Kinds of random bursts.
  localparam int BurstFill   = 0;
  localparam int BurstDrain  = 1;
  localparam int BurstMix    = 2;
  localparam int BurstSearch = 3;

  localparam logic signed [DataW-1:0] WordMax  = 32'sh7FFF_FFFF;
  localparam logic signed [DataW-1:0] WordMin  = 32'sh8000_0000;
  localparam logic signed [DataW-1:0] WordZero = 32'sh0000_0000;
  localparam logic signed [DataW-1:0] WordOnes = 32'shFFFF_FFFF;

  // Queue scoreboard: keeps its own copy of the stored words and the pointers,
  // turns every accepted request into the results it must cause, and checks
  // the results of the block against them in order.
  class fqs_scoreboard;
    logic signed [DataW-1:0] slots [QueueDepth];
    int unsigned             head_idx;
    int unsigned             tail_idx;
    int unsigned             fill;
    result_t                 expected_results [$];
    int unsigned             errors;

    function new();
      head_idx = 0;
      tail_idx = 0;
      fill     = 0;
      errors   = 0;
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    // Works out the results of one accepted request and updates the queue copy.
    function void note_request(logic [1:0] op, logic signed [DataW-1:0] push_word,
                               logic signed [DataW-1:0] key);
      result_t     r;
      result_t     hit;
      int unsigned idx;
      int unsigned hits;
      r      = '0;
      r.last = 1'b1;
      case (op)
        FUNC_ENQ: begin
          if (fill == QueueDepth) begin
            r.status = ST_FULL;
          end else begin
            slots[tail_idx] = push_word;
            tail_idx = (tail_idx + 1) % QueueDepth;
            fill++;
          end
        end
        FUNC_DEQ: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.data_out = slots[head_idx];
            head_idx = (head_idx + 1) % QueueDepth;
            fill--;
          end
        end
        FUNC_PEEK: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.data_out = slots[head_idx];
          end
        end
        default: begin
          // A search reports every equal entry from head to tail, then the count.
          if (fill == 0) begin
            r.status = ST_EMPTY;
          end else begin
            idx  = head_idx;
            hits = 0;
            for (int unsigned i = 0; i < fill; i++) begin
              if (slots[idx] == key) begin
                hit                = '0;
                hit.is_match       = 1'b1;
                hit.match_position = PosW'(i + 1);
                expected_results.push_back(hit);
                hits++;
              end
              idx = (idx + 1) % QueueDepth;
            end
            r.match_total = PosW'(hits);
          end
        end
      endcase
      expected_results.push_back(r);
    endfunction

    // Compares one accepted result with the oldest expectation.
    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        $error("result with no request pending: status %0d data_out %0d last %0d",
               got.status, got.data_out, got.last);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.data_out !== want.data_out) begin
        $error("data_out: expected %0d, got %0d", want.data_out, got.data_out);
        errors++;
      end
      if (got.is_match !== want.is_match) begin
        $error("is_match: expected %0d, got %0d", want.is_match, got.is_match);
        errors++;
      end
      if (got.match_position !== want.match_position) begin
        $error("match_position: expected %0d, got %0d", want.match_position,
               got.match_position);
        errors++;
      end
      if (got.match_total !== want.match_total) begin
        $error("match_total: expected %0d, got %0d", want.match_total, got.match_total);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  // Every input of the block starts at a known value.
  logic                    clk_i        = 1'b0;
  logic                    rst_ni       = 1'b0;
  logic                    in_valid_i   = 1'b0;
  logic                    in_ready_o;
  logic [1:0]              func_i       = FUNC_PEEK;
  logic signed [DataW-1:0] push_value_i = '0;
  logic signed [DataW-1:0] search_key_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i  = 1'b0;
  logic [1:0]              status_o;
  logic signed [DataW-1:0] data_out_o;
  logic                    is_match_o;
  logic [PosW-1:0]         match_position_o;
  logic [PosW-1:0]         match_total_o;
  logic                    last_o;

  fqs_scoreboard board = new();

  // Sender state: the gap before the next request is drawn when the current
  // one is accepted, so valid is lowered in that same step or not at all.
  int unsigned             tx_gap      = 0;
  bit                      tx_no_idle  = 1'b0;
  int unsigned             items_sent  = 0;
  int unsigned             cycle_count = 0;
  logic signed [DataW-1:0] word_pool [4];

  fifo_queue_with_search u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .func_i           (func_i),
    .push_value_i     (push_value_i),
    .search_key_i     (search_key_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .data_out_o       (data_out_o),
    .is_match_o       (is_match_o),
    .match_position_o (match_position_o),
    .match_total_o    (match_total_o),
    .last_o           (last_o)
  );

  always #1 clk_i = ~clk_i;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("fifo_queue_with_search regression: fail");
      $finish;
    end
  end

  // Picks a word for a burst pool: half the time random, else one of the extremes.
  function automatic logic signed [DataW-1:0] draw_pool_word();
    logic signed [DataW-1:0] w;
    case ($urandom_range(0, 7))
      0: w = WordMax;
      1: w = WordMin;
      2: w = WordZero;
      3: w = WordOnes;
      default: w = $urandom();
    endcase
    return w;
  endfunction

  // Words for enqueue and search keys come mostly from the small pool so that
  // searches hit repeated entries; the rest are fully random.
  function automatic logic signed [DataW-1:0] draw_word();
    logic signed [DataW-1:0] w;
    if ($urandom_range(0, 3) == 0) begin
      w = $urandom();
    end else begin
      w = word_pool[$urandom_range(0, 3)];
    end
    return w;
  endfunction

  // Offers one request and returns in the step where it is accepted. The
  // handshake is judged on the values held just before the edge, since all
  // driving happens through nonblocking assignments.
  task automatic send_request(input logic [1:0] op, input logic signed [DataW-1:0] push_word,
                              input logic signed [DataW-1:0] key);
    repeat (tx_gap) @(posedge clk_i);
    in_valid_i   <= 1'b1;
    func_i       <= op;
    push_value_i <= push_word;
    search_key_i <= key;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_request(op, push_word, key);
    items_sent++;
    tx_gap = tx_no_idle ? 0 : $urandom_range(0, 8);
    if (tx_gap != 0) begin
      in_valid_i <= 1'b0;
    end
  endtask

  // Holds the input idle until every expected result has come back.
  task automatic wait_until_drained();
    if (tx_gap == 0) begin
      in_valid_i <= 1'b0;
    end
    do @(posedge clk_i); while (board.pending() != 0);
    tx_gap = 0;
  endtask

  // Receiver: draws a stall of random length after each accepted result, with
  // stretches of no stalling, and one long stall that backs the block up until
  // its input stops taking requests.
  initial begin : result_sink
    int unsigned wait_left;
    int unsigned results_seen;
    bit          rx_no_idle;
    result_t     got;
    wait_left    = 0;
    results_seen = 0;
    rx_no_idle   = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got = {status_o, data_out_o, is_match_o, match_position_o, match_total_o, last_o};
        board.check_result(got);
        results_seen++;
        if (results_seen % 30 == 0) begin
          rx_no_idle = ($urandom_range(0, 3) == 0);
        end
        if (results_seen == HoldAfter) begin
          wait_left = HoldCycles;
        end else begin
          wait_left = rx_no_idle ? 0 : $urandom_range(0, 8);
        end
      end else if (wait_left != 0) begin
        wait_left--;
      end
      out_ready_i <= (wait_left == 0);
    end
  end

  initial begin : request_source
    int          burst;
    int          kind;
    int unsigned n;
    logic [1:0]  op;
    burst = 0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: every operation on an empty queue, the extreme words,
    // a search with two hits, one hit and none, and draining past empty.
    send_request(FUNC_PEEK, WordOnes, WordZero);
    send_request(FUNC_DEQ, WordMin, WordMax);
    send_request(FUNC_SRCH, WordMax, WordZero);
    send_request(FUNC_ENQ, WordMax, WordOnes);
    send_request(FUNC_ENQ, WordMin, WordZero);
    send_request(FUNC_ENQ, WordZero, WordMin);
    send_request(FUNC_ENQ, WordOnes, WordMax);
    send_request(FUNC_ENQ, WordMax, WordZero);
    send_request(FUNC_SRCH, WordZero, WordMax);
    send_request(FUNC_SRCH, WordMax, WordMin);
    send_request(FUNC_SRCH, WordMin, 32'sd12345);
    send_request(FUNC_PEEK, WordZero, WordZero);
    send_request(FUNC_DEQ, WordZero, WordZero);
    send_request(FUNC_DEQ, WordOnes, WordOnes);
    send_request(FUNC_SRCH, WordZero, WordOnes);
    send_request(FUNC_DEQ, WordZero, WordZero);
    send_request(FUNC_DEQ, WordZero, WordZero);
    send_request(FUNC_DEQ, WordZero, WordZero);
    send_request(FUNC_DEQ, WordMax, WordMin);
    send_request(FUNC_PEEK, WordMin, WordMax);
    wait_until_drained();

    // Random part in bursts. The first burst fills the queue mostly from a pool of
    // one repeated word, runs into the full case and then searches for such a word.
    while (items_sent < ItemsTarget) begin
      kind       = (burst == 0) ? BurstFill : $urandom_range(BurstFill, BurstSearch);
      tx_no_idle = ($urandom_range(0, 3) == 0);
      if (burst == 0 || $urandom_range(0, 2) == 0) begin
        word_pool[0] = draw_pool_word();
        for (int k = 1; k < 4; k++) word_pool[k] = word_pool[0];
      end else begin
        for (int k = 0; k < 4; k++) word_pool[k] = draw_pool_word();
      end

      case (kind)
        BurstFill: begin
          n = (burst == 0) ? QueueDepth + 2 : $urandom_range(4, 20);
          repeat (n) send_request(FUNC_ENQ, draw_word(), $urandom());
          send_request(FUNC_SRCH, $urandom(), draw_word());
        end
        BurstDrain: begin
          n = $urandom_range(3, 18);
          repeat (n) begin
            op = ($urandom_range(0, 3) == 0) ? FUNC_PEEK : FUNC_DEQ;
            send_request(op, $urandom(), $urandom());
          end
          send_request(FUNC_SRCH, $urandom(), draw_word());
        end
        BurstSearch: begin
          n = $urandom_range(3, 8);
          repeat (n) begin
            op = ($urandom_range(0, 2) == 0) ? FUNC_ENQ : FUNC_SRCH;
            send_request(op, draw_word(), draw_word());
          end
        end
        BurstMix: begin
          // Unordered mix of all operations.
          n = $urandom_range(8, 24);
          repeat (n) begin
            op = 2'($urandom_range(0, 3));
            send_request(op, draw_word(), draw_word());
          end
        end
        default: begin
        end
      endcase

      // A mid-run pause with nothing in flight.
      if (burst == 5) begin
        wait_until_drained();
      end
      burst++;
    end

    wait_until_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (board.pending() == 0 && board.errors == 0) begin
      $display("fifo_queue_with_search regression: pass");
    end else begin
      $display("fifo_queue_with_search regression: fail");
    end
    $finish;
  end

endmodule
